// ===== hw/rtl/pprm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pprm_pkg - pulse period rpm meter package
// field widths, register codes, reset values, payload types and sequencer codes
// ----------------------------------------------------------------------------
package pprm_pkg;

    // fixed field widths
    localparam int CAP_W      = 16;
    localparam int OVF_W      = 8;
    localparam int THR_W      = 16;
    localparam int FREQ_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int TALLY_W    = 16;
    localparam int SUM_W      = 48;
    localparam int RATE_W     = 24;
    localparam int RATIO_W    = 8;
    localparam int CFG_DATA_W = 24;
    localparam int TICK_W     = 32;

    // signed capture difference, one overflow folded in
    localparam int DIFF_W     = CAP_W + 2;

    // default fraction bits of the frequency outputs
    localparam int FRAC_BITS_DEF = 8;

    // register reset values
    localparam logic [RATE_W-1:0]  TICK_RATE_RST = RATE_W'(281250);
    localparam logic [RATIO_W-1:0] RATIO_RST     = RATIO_W'(1);

    // ticks added for one timer overflow
    localparam logic [DIFF_W-1:0]  OVF_SPAN = DIFF_W'(65536);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TICK_RATE                = 2'd0,
        CFG_PULSES_PER_ROTATION      = 2'd1,
        CFG_PULSES_PER_REVOLUTION    = 2'd2,
        CFG_REVOLUTIONS_PER_ROTATION = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic        [CAP_W-1:0] capture_count;
        logic        [OVF_W-1:0] overflow_count;
        logic signed [THR_W-1:0] thrust_command;
    } t_pulse_item;

    typedef struct packed {
        logic [FREQ_W-1:0]  motor_freq;
        logic [FREQ_W-1:0]  rotation_freq;
        logic [FREQ_W-1:0]  average_freq;
        logic [FREQ_W-1:0]  prior_freq;
        logic [COUNT_W-1:0] rotations_done;
        logic [TALLY_W-1:0] samples_held;
        logic               motor_stopped;
    } t_result_item;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_ACCUM,
        ST_OUT
    } t_state;

    // division jobs run on the shared divider
    typedef enum logic [2:0] {
        OP_ROT,
        OP_MOTOR,
        OP_RFREQ1,
        OP_RFREQ2,
        OP_AVG
    } t_div_op;

endpackage
`default_nettype wire

// ===== hw/rtl/pprm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pprm_if - channel interfaces of the pulse period rpm meter
// pulse input, result output and register write channels
// ----------------------------------------------------------------------------
interface pprm_pulse_if;
    logic                  valid;
    logic                  ready;
    pprm_pkg::t_pulse_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pprm_result_if;
    logic                   valid;
    logic                   ready;
    pprm_pkg::t_result_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pprm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    pprm_pkg::t_cfg_addr                  addr;
    logic [pprm_pkg::CFG_DATA_W-1:0]      wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pprm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pprm_div - restoring divider
// one quotient bit per cycle for each of the DW dividend bits, done pulses once
// ----------------------------------------------------------------------------
module pprm_div #(
    parameter int DW = 48,
    parameter int VW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_den;

    logic [VW:0]   trial;
    logic [VW:0]   trial_sub;
    logic          fits;
    logic [VW-1:0] n_rem;

    // one restoring step
    always_comb begin
        trial     = {r_rem, r_quo[DW-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = (trial >= {1'b0, r_den});
        n_rem     = fits ? trial_sub[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // quotient bits shift in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/pulse_period_rpm_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_period_rpm_meter - period measuring tachometer
// turns timer captures of sensor pulses into motor, per-rotation and averaged
// frequencies in unsigned fixed point with FRAC_BITS fraction bits
// ----------------------------------------------------------------------------
//
//  port       dir  role       transaction carries
//  i_pulse    in   sink       capture_count, overflow_count, thrust_command
//  o_result   out  source     motor/rotation/average/prior freq, rotations_done,
//                             samples_held, motor_stopped
//  i_cfg      in   sink       register index and write data, always ready
//
//  one pulse at a time; every quotient comes from a single shared restoring
//  divider, one bit a cycle: a launch, one step per dividend bit, then done
//  a stopped pulse needs no division; a running pulse divides for its
//  rotation count and then its motor frequency (skipped when the gap is not
//  positive); a pulse that completes a rotation adds the two rotation
//  frequency divisions (skipped on a zero tick sum) and the average one
//  a finished result waits in the output register while the next pulse is
//  accepted; a stalled sink holds the sequencer only at the result hand-off
//  synchronous active-low reset clears all measurement state and loads the
//  register defaults (tick rate 281250, the three ratios 1)
//
module pulse_period_rpm_meter #(
    parameter int FRAC_BITS = pprm_pkg::FRAC_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pprm_pulse_if.sink     i_pulse,
    pprm_result_if.source  o_result,
    pprm_cfg_if.sink       i_cfg
);

    // dividend wide enough for the frequency sum and for the scaled tick rate
    localparam int DW = (pprm_pkg::RATE_W + FRAC_BITS > pprm_pkg::SUM_W) ?
                        (pprm_pkg::RATE_W + FRAC_BITS) : pprm_pkg::SUM_W;
    localparam int VW = pprm_pkg::TICK_W;

    localparam int FREQ_W  = pprm_pkg::FREQ_W;
    localparam int COUNT_W = pprm_pkg::COUNT_W;
    localparam int TALLY_W = pprm_pkg::TALLY_W;
    localparam int SUM_W   = pprm_pkg::SUM_W;
    localparam int CAP_W   = pprm_pkg::CAP_W;
    localparam int DIFF_W  = pprm_pkg::DIFF_W;
    localparam int RATIO_W = pprm_pkg::RATIO_W;
    localparam int RATE_W  = pprm_pkg::RATE_W;

    // divide-by-zero guard: a zero ratio acts as one
    function automatic logic [RATIO_W-1:0] nz(input logic [RATIO_W-1:0] v);
        return (v == '0) ? RATIO_W'(1) : v;
    endfunction

    function automatic logic [FREQ_W-1:0] sat32(input logic [DW-1:0] v);
        return (|v[DW-1:FREQ_W]) ? '1 : v[FREQ_W-1:0];
    endfunction

    // configuration registers
    logic [RATE_W-1:0]  r_tick_rate;
    logic [RATIO_W-1:0] r_ppr_rot;
    logic [RATIO_W-1:0] r_ppr_rev;
    logic [RATIO_W-1:0] r_rev_rot;

    // measurement state
    logic [CAP_W-1:0]   r_last_capture;
    logic [COUNT_W-1:0] r_pulse_total;
    logic [COUNT_W-1:0] r_last_rot;
    logic [VW-1:0]      r_tick_sum;
    logic [SUM_W-1:0]   r_freq_sum;
    logic [TALLY_W-1:0] r_tally;
    logic [FREQ_W-1:0]  r_motor;
    logic [FREQ_W-1:0]  r_rot_freq;
    logic [FREQ_W-1:0]  r_avg;
    logic [FREQ_W-1:0]  r_prior;
    logic [COUNT_W-1:0] r_rot_count;
    logic               r_stopped;

    // sequencer
    pprm_pkg::t_state   r_state, n_state;
    pprm_pkg::t_div_op  r_op, n_op;

    // per-pulse working registers
    logic [DIFF_W-1:0]  r_diff;
    logic [DW-1:0]      r_quot;
    logic [COUNT_W-1:0] r_rdiff;

    // output register
    logic                   r_out_valid;
    pprm_pkg::t_result_item r_out_data;

    logic pulse_acc;
    logic cfg_acc;
    logic pulse_stopped;
    logic div_start;
    logic div_done;
    logic load_out;
    logic [DW-1:0] div_quot;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic [DIFF_W-1:0] pulse_diff;
    logic diff_pos;
    logic diff_zero;
    logic rot_adv;
    logic tick_zero;
    logic [VW-1:0]      n_tick_sum;
    logic [SUM_W:0]     freq_sum_ext;
    logic [SUM_W-1:0]   n_freq_sum;
    logic [TALLY_W-1:0] n_tally;
    logic [DW-1:0]      scaled_rate;
    logic [CAP_W+RATIO_W:0]     motor_den;
    logic [TALLY_W+RATIO_W-1:0] avg_den;

    assign pulse_acc = i_pulse.valid && i_pulse.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // motor counts as stopped with no positive thrust or more than one overflow
    assign pulse_stopped = (i_pulse.data.thrust_command <= 16'sd0) ||
                           (i_pulse.data.overflow_count > pprm_pkg::OVF_W'(1));

    // tick difference, one overflow folded in as a full timer span
    assign pulse_diff = {2'b00, i_pulse.data.capture_count} - {2'b00, r_last_capture} +
                        ((i_pulse.data.overflow_count != '0) ? pprm_pkg::OVF_SPAN : '0);

    assign diff_zero = (r_diff == '0);
    assign diff_pos  = !r_diff[DIFF_W-1] && !diff_zero;

    // accumulation step, difference sign-extended so tick_sum wraps like the count
    assign n_tick_sum   = r_tick_sum + VW'($signed(r_diff));
    assign tick_zero    = (n_tick_sum == '0);
    assign freq_sum_ext = {1'b0, r_freq_sum} + (SUM_W + 1)'(r_motor);
    assign n_freq_sum   = freq_sum_ext[SUM_W] ? '1 : freq_sum_ext[SUM_W-1:0];
    assign n_tally      = (r_tally == '1) ? r_tally : r_tally + TALLY_W'(1);
    assign rot_adv      = (r_rot_count > r_last_rot);

    // divider operands
    assign scaled_rate = DW'(r_tick_rate) << FRAC_BITS;
    assign motor_den   = r_diff[CAP_W:0] * nz(r_ppr_rev);
    assign avg_den     = r_tally * nz(r_rev_rot);

    always_comb begin
        case (r_op)
            pprm_pkg::OP_ROT: begin
                div_dividend = DW'(r_pulse_total);
                div_divisor  = VW'(nz(r_ppr_rot));
            end
            pprm_pkg::OP_MOTOR: begin
                div_dividend = scaled_rate;
                div_divisor  = VW'(motor_den);
            end
            pprm_pkg::OP_RFREQ1: begin
                div_dividend = scaled_rate;
                div_divisor  = r_tick_sum;
            end
            pprm_pkg::OP_RFREQ2: begin
                div_dividend = r_quot;
                div_divisor  = r_rdiff;
            end
            pprm_pkg::OP_AVG: begin
                div_dividend = DW'(r_freq_sum);
                div_divisor  = VW'(avg_den);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = VW'(1);
            end
        endcase
    end

    pprm_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // next state and next division job
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            pprm_pkg::ST_IDLE: begin
                if (pulse_acc) begin
                    if (pulse_stopped) begin
                        n_state = pprm_pkg::ST_OUT;
                    end else begin
                        n_state = pprm_pkg::ST_LAUNCH;
                        n_op    = pprm_pkg::OP_ROT;
                    end
                end
            end
            pprm_pkg::ST_LAUNCH: begin
                n_state = pprm_pkg::ST_WAIT;
            end
            pprm_pkg::ST_WAIT: begin
                if (div_done) begin
                    case (r_op)
                        pprm_pkg::OP_ROT: begin
                            if (diff_pos) begin
                                n_state = pprm_pkg::ST_LAUNCH;
                                n_op    = pprm_pkg::OP_MOTOR;
                            end else begin
                                n_state = pprm_pkg::ST_ACCUM;
                            end
                        end
                        pprm_pkg::OP_MOTOR: begin
                            n_state = pprm_pkg::ST_ACCUM;
                        end
                        pprm_pkg::OP_RFREQ1: begin
                            n_state = pprm_pkg::ST_LAUNCH;
                            n_op    = pprm_pkg::OP_RFREQ2;
                        end
                        pprm_pkg::OP_RFREQ2: begin
                            n_state = pprm_pkg::ST_LAUNCH;
                            n_op    = pprm_pkg::OP_AVG;
                        end
                        pprm_pkg::OP_AVG: begin
                            n_state = pprm_pkg::ST_OUT;
                        end
                        default: begin
                            n_state = pprm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pprm_pkg::ST_ACCUM: begin
                if (rot_adv) begin
                    // zero tick sum saturates the rotation frequency, skip its divisions
                    n_state = pprm_pkg::ST_LAUNCH;
                    n_op    = tick_zero ? pprm_pkg::OP_AVG : pprm_pkg::OP_RFREQ1;
                end else begin
                    n_state = pprm_pkg::ST_OUT;
                end
            end
            pprm_pkg::ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = pprm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pprm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_pulse.ready = (r_state == pprm_pkg::ST_IDLE);
        div_start     = (r_state == pprm_pkg::ST_LAUNCH);
        load_out      = (r_state == pprm_pkg::ST_OUT) && (!r_out_valid || o_result.ready);
    end

    // control and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pprm_pkg::ST_IDLE;
            r_op           <= pprm_pkg::OP_ROT;
            r_tick_rate    <= pprm_pkg::TICK_RATE_RST;
            r_ppr_rot      <= pprm_pkg::RATIO_RST;
            r_ppr_rev      <= pprm_pkg::RATIO_RST;
            r_rev_rot      <= pprm_pkg::RATIO_RST;
            r_last_capture <= '0;
            r_pulse_total  <= '0;
            r_last_rot     <= '0;
            r_tick_sum     <= '0;
            r_freq_sum     <= '0;
            r_tally        <= '0;
            r_motor        <= '0;
            r_rot_freq     <= '0;
            r_avg          <= '0;
            r_prior        <= '0;
            r_rot_count    <= '0;
            r_stopped      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;

            if (cfg_acc) begin
                case (i_cfg.addr)
                    pprm_pkg::CFG_TICK_RATE:                r_tick_rate <= i_cfg.wdata;
                    pprm_pkg::CFG_PULSES_PER_ROTATION:      r_ppr_rot <= i_cfg.wdata[RATIO_W-1:0];
                    pprm_pkg::CFG_PULSES_PER_REVOLUTION:    r_ppr_rev <= i_cfg.wdata[RATIO_W-1:0];
                    pprm_pkg::CFG_REVOLUTIONS_PER_ROTATION: r_rev_rot <= i_cfg.wdata[RATIO_W-1:0];
                    default: ;
                endcase
            end

            if (pulse_acc) begin
                r_last_capture <= i_pulse.data.capture_count;
                r_stopped      <= pulse_stopped;
                if (pulse_stopped) begin
                    // stopped: clear motor/rotation/avg freqs, pulse counts; sums kept
                    r_prior       <= r_rot_freq;
                    r_motor       <= '0;
                    r_rot_freq    <= '0;
                    r_avg         <= '0;
                    r_pulse_total <= '0;
                    r_last_rot    <= '0;
                end else begin
                    r_prior       <= r_motor;
                    r_pulse_total <= r_pulse_total + COUNT_W'(1);
                end
            end

            if ((r_state == pprm_pkg::ST_WAIT) && div_done) begin
                case (r_op)
                    pprm_pkg::OP_ROT: begin
                        r_rot_count <= div_quot[COUNT_W-1:0];
                        // zero gap saturates, backwards gap reads as standstill
                        if (!diff_pos) begin
                            r_motor <= diff_zero ? '1 : '0;
                        end
                    end
                    pprm_pkg::OP_MOTOR: begin
                        r_motor <= sat32(div_quot);
                    end
                    pprm_pkg::OP_RFREQ2: begin
                        r_rot_freq <= sat32(div_quot);
                    end
                    pprm_pkg::OP_AVG: begin
                        r_avg      <= sat32(div_quot);
                        r_freq_sum <= '0;
                        r_tally    <= '0;
                        r_tick_sum <= '0;
                    end
                    default: ;
                endcase
            end

            if (r_state == pprm_pkg::ST_ACCUM) begin
                r_freq_sum <= n_freq_sum;
                r_tally    <= n_tally;
                r_tick_sum <= n_tick_sum;
                if (rot_adv) begin
                    r_last_rot <= r_rot_count;
                    if (tick_zero) begin
                        r_rot_freq <= '1;
                    end
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        if (pulse_acc) begin
            r_diff <= pulse_diff;
        end
        if ((r_state == pprm_pkg::ST_WAIT) && div_done && (r_op == pprm_pkg::OP_RFREQ1)) begin
            r_quot <= div_quot;
        end
        if ((r_state == pprm_pkg::ST_ACCUM) && rot_adv) begin
            r_rdiff <= r_rot_count - r_last_rot;
        end
        if (load_out) begin
            r_out_data.motor_freq     <= r_motor;
            r_out_data.rotation_freq  <= r_rot_freq;
            r_out_data.average_freq   <= r_avg;
            r_out_data.prior_freq     <= r_prior;
            r_out_data.rotations_done <= r_rot_count;
            r_out_data.samples_held   <= r_tally;
            r_out_data.motor_stopped  <= r_stopped;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

endmodule
`default_nettype wire

// ===== tb/tb_pulse_period_rpm_meter.sv =====
// ----------------------------------------------------------------------------
// tb_pulse_period_rpm_meter - self-checking bench of the period tachometer
// drives pulse transactions and register writes, predicts every result
// transaction with a cycle-free model of the tachometer and checks the
// outputs field by field under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_pulse_period_rpm_meter;

    import pprm_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int DRAIN_LIMIT = 20000;    // cycles allowed for outstanding results
    localparam int HOLD_CYCLES = 2000;     // long sink hold-off of the pressure test
    localparam int PRINT_LIMIT = 40;       // mismatch lines printed before going quiet

    logic i_clk;
    logic i_rst_n;

    pprm_pulse_if  pulse_ch ();
    pprm_result_if result_ch ();
    pprm_cfg_if    cfg_ch ();

    pulse_period_rpm_meter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pulse  (pulse_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // predicted tachometer state: registers and measurement state
    // ------------------------------------------------------------------------
    logic [RATE_W-1:0]  rate_q;
    logic [RATIO_W-1:0] pulses_rot_q;
    logic [RATIO_W-1:0] pulses_rev_q;
    logic [RATIO_W-1:0] revs_rot_q;

    logic [CAP_W-1:0]   prev_capture;
    logic [COUNT_W-1:0] pulse_total;
    logic [COUNT_W-1:0] rotation_mark;
    logic [TICK_W-1:0]  tick_acc;
    logic [SUM_W-1:0]   freq_acc;
    logic [TALLY_W-1:0] sample_cnt;
    logic [FREQ_W-1:0]  motor_f;
    logic [FREQ_W-1:0]  rotation_f;
    logic [FREQ_W-1:0]  average_f;
    logic [FREQ_W-1:0]  prior_f;
    logic [COUNT_W-1:0] rotation_cnt;

    // results still owed by the block, oldest first
    t_result_item tach_expected[$];

    int          mismatches;
    logic [15:0] tx_cap;        // capture value of the last pulse sent
    int          burst_left;
    bit          gaps_on;       // source idles between bursts
    bit          rx_stalls;     // sink follows its stall pattern
    int          hold_left;     // remaining cycles of a long sink hold-off

    // ------------------------------------------------------------------------
    // clock, time limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction helpers
    // ------------------------------------------------------------------------
    // a ratio register of zero behaves as one
    function automatic logic [RATIO_W-1:0] at_least_one(logic [RATIO_W-1:0] v);
        return (v == '0) ? RATIO_W'(1) : v;
    endfunction

    function automatic logic [FREQ_W-1:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[FREQ_W-1:0];
    endfunction

    // one pulse through the tachometer: updates the predicted state and
    // returns the result transaction it must produce
    function automatic t_result_item advance_tacho(t_pulse_item p);
        t_result_item       r;
        logic               halted;
        int                 diff;
        logic [COUNT_W-1:0] rot;
        logic [63:0]        scaled;
        logic [63:0]        fsum;

        scaled = 64'(rate_q) << FRAC;
        // thrust not positive, or the gap spans more than one timer overflow
        halted = p.thrust_command[THR_W-1] || (p.thrust_command == '0) ||
                 (p.overflow_count > OVF_W'(1));

        if (halted) begin
            prior_f       = rotation_f;
            motor_f       = '0;
            rotation_f    = '0;
            average_f     = '0;
            pulse_total   = '0;
            rotation_mark = '0;
        end else begin
            pulse_total  = pulse_total + 32'd1;
            rot          = pulse_total / 32'(at_least_one(pulses_rot_q));
            rotation_cnt = rot;

            diff = int'({16'd0, p.capture_count}) - int'({16'd0, prev_capture});
            if (p.overflow_count != '0)
                diff += 65536;

            prior_f = motor_f;
            if (diff == 0) begin
                motor_f = '1;
            end else if (diff < 0) begin
                motor_f = '0;
            end else begin
                motor_f = clamp32(scaled / (64'(diff) * 64'(at_least_one(pulses_rev_q))));
            end

            fsum     = 64'(freq_acc) + 64'(motor_f);
            freq_acc = (fsum > 64'hFFFF_FFFF_FFFF) ? '1 : fsum[SUM_W-1:0];
            if (sample_cnt != '1)
                sample_cnt = sample_cnt + 16'd1;
            // backwards captures subtract, wrapping at 32 bits
            tick_acc = tick_acc + 32'(diff);

            // rotation count moved on: close the rotation
            if (rot > rotation_mark) begin
                if (tick_acc == '0) begin
                    rotation_f = '1;
                end else begin
                    rotation_f = clamp32((scaled / 64'(tick_acc)) / 64'(rot - rotation_mark));
                end
                average_f = clamp32(64'(freq_acc) /
                                    (64'(sample_cnt) * 64'(at_least_one(revs_rot_q))));
                freq_acc      = '0;
                sample_cnt    = '0;
                rotation_mark = rot;
                tick_acc      = '0;
            end
        end

        prev_capture = p.capture_count;

        r.motor_freq     = motor_f;
        r.rotation_freq  = rotation_f;
        r.average_freq   = average_f;
        r.prior_freq     = prior_f;
        r.rotations_done = rotation_cnt;
        r.samples_held   = sample_cnt;
        r.motor_stopped  = halted;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // monitor: samples at the rising edge, checks results first, then
    // applies register writes and predicts accepted pulses
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result_item got;
        t_result_item want;

        if (!i_rst_n) begin
            rate_q        = TICK_RATE_RST;
            pulses_rot_q  = RATIO_RST;
            pulses_rev_q  = RATIO_RST;
            revs_rot_q    = RATIO_RST;
            prev_capture  = '0;
            pulse_total   = '0;
            rotation_mark = '0;
            tick_acc      = '0;
            freq_acc      = '0;
            sample_cnt    = '0;
            motor_f       = '0;
            rotation_f    = '0;
            average_f     = '0;
            prior_f       = '0;
            rotation_cnt  = '0;
            tach_expected.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (tach_expected.size() == 0) begin
                    report_mismatch("result with nothing expected, motor_freq",
                                    got.motor_freq, '0);
                end else begin
                    want = tach_expected.pop_front();
                    if (got.motor_freq !== want.motor_freq)
                        report_mismatch("motor_freq", got.motor_freq, want.motor_freq);
                    if (got.rotation_freq !== want.rotation_freq)
                        report_mismatch("rotation_freq", got.rotation_freq, want.rotation_freq);
                    if (got.average_freq !== want.average_freq)
                        report_mismatch("average_freq", got.average_freq, want.average_freq);
                    if (got.prior_freq !== want.prior_freq)
                        report_mismatch("prior_freq", got.prior_freq, want.prior_freq);
                    if (got.rotations_done !== want.rotations_done)
                        report_mismatch("rotations_done", got.rotations_done,
                                        want.rotations_done);
                    if (got.samples_held !== want.samples_held)
                        report_mismatch("samples_held", got.samples_held, want.samples_held);
                    if (got.motor_stopped !== want.motor_stopped)
                        report_mismatch("motor_stopped", got.motor_stopped, want.motor_stopped);
                end
            end

            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.addr)
                    CFG_TICK_RATE:                rate_q       = cfg_ch.wdata[RATE_W-1:0];
                    CFG_PULSES_PER_ROTATION:      pulses_rot_q = cfg_ch.wdata[RATIO_W-1:0];
                    CFG_PULSES_PER_REVOLUTION:    pulses_rev_q = cfg_ch.wdata[RATIO_W-1:0];
                    CFG_REVOLUTIONS_PER_ROTATION: revs_rot_q   = cfg_ch.wdata[RATIO_W-1:0];
                    default: ;
                endcase
            end

            if (pulse_ch.valid && pulse_ch.ready)
                tach_expected.push_back(advance_tacho(pulse_ch.data));
        end
    end

    // ------------------------------------------------------------------------
    // sink: stall pattern of its own, always-ready stretches, long hold-off
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] pattern;
        int          cycle;

        result_ch.ready = 1'b0;
        pattern         = '1;
        cycle           = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (!rx_stalls) begin
                result_ch.ready <= 1'b1;
            end else begin
                // ready follows a rotating pattern made of the OR of two random words
                if (cycle % 64 == 0)
                    pattern = $urandom | $urandom;
                result_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[31:1]};
            end
            cycle++;
        end
    end

    // ------------------------------------------------------------------------
    // source side tasks
    // ------------------------------------------------------------------------
    // offers one pulse, holds it until accepted, then maybe idles between bursts
    task automatic send_pulse(logic [CAP_W-1:0] cap, logic [OVF_W-1:0] ovf,
                              logic [THR_W-1:0] thr);
        int gap;

        @(negedge i_clk);
        pulse_ch.valid <= 1'b1;
        pulse_ch.data  <= '{capture_count: cap, overflow_count: ovf, thrust_command: thr};
        do @(posedge i_clk); while (!pulse_ch.ready);
        tx_cap = cap;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 20);
                gap        = $urandom_range(1, 12);
                @(negedge i_clk);
                pulse_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_reg(t_cfg_addr idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.wdata <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stops offering pulses and waits, with a bound, until every result is in
    task automatic wait_results_done(int settle);
        int waited;

        @(negedge i_clk);
        pulse_ch.valid <= 1'b0;
        waited = 0;
        while (tach_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (tach_expected.size() != 0) begin
            report_mismatch("results never delivered, count", tach_expected.size(), 0);
            tach_expected.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_ratios(logic [RATIO_W-1:0] per_rot, logic [RATIO_W-1:0] per_rev,
                              logic [RATIO_W-1:0] revs);
        // upper data bits are junk: only the low byte belongs to a ratio
        write_reg(CFG_PULSES_PER_ROTATION, {16'($urandom), per_rot});
        write_reg(CFG_PULSES_PER_REVOLUTION, {16'($urandom), per_rev});
        write_reg(CFG_REVOLUTIONS_PER_ROTATION, {16'($urandom), revs});
    endtask

    // mostly well-formed pulse trains: captures advance by a realistic period
    // with the overflow flag set on timer wrap; the rest is broken timing
    task automatic drive_pulse_train(int count, int noise_pct);
        int unsigned      period;
        int               nxt;
        logic [THR_W-1:0] thr;

        repeat (count) begin
            thr = THR_W'($urandom_range(1, 32767));
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 2))
                    0: send_pulse(CAP_W'($urandom), OVF_W'($urandom), THR_W'($urandom));
                    1: send_pulse(tx_cap + CAP_W'($urandom_range(100, 5000)), OVF_W'(0),
                                  THR_W'(-int'($urandom_range(0, 32768))));
                    default: send_pulse(CAP_W'($urandom), OVF_W'($urandom_range(0, 1)), thr);
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0:       period = $urandom_range(0, 3);
                    1:       period = $urandom_range(60000, 65535);
                    default: period = $urandom_range(150, 20000);
                endcase
                nxt = int'(tx_cap) + int'(period);
                send_pulse(CAP_W'(nxt), OVF_W'(nxt >> 16), thr);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset defaults, field extremes and the corner cases of the tachometer
    task automatic test_directed_cases();
        send_pulse(16'h1234, 8'd0,   16'h0000);   // zero thrust: stopped
        send_pulse(16'h0000, 8'd0,   16'h8000);   // most negative thrust
        send_pulse(16'h0000, 8'd0,   16'h0001);   // zero difference, zero tick sum
        send_pulse(16'h0001, 8'd0,   16'h7FFF);   // one tick: fastest finite
        send_pulse(16'h1000, 8'd0,   16'h0100);
        send_pulse(16'h0800, 8'd0,   16'h0100);   // capture ran backwards
        send_pulse(16'h0800, 8'd1,   16'h0100);   // one overflow, equal capture
        send_pulse(16'hFFFF, 8'd1,   16'h0200);   // overflow with a large forward difference
        send_pulse(16'h0000, 8'd1,   16'h0001);   // overflow across timer wrap
        send_pulse(16'h4000, 8'd2,   16'h7FFF);   // two overflows: stopped
        send_pulse(16'h4000, 8'd255, 16'h7FFF);   // overflow count at its top
        send_pulse(16'hFFFF, 8'd0,   16'hFFFF);   // thrust of minus one
        send_pulse(16'h0000, 8'd1,   16'h0001);

        // two pulses a rotation whose tick differences cancel
        wait_results_done(8);
        set_ratios(8'd2, 8'd2, 8'd3);
        send_pulse(16'h2000, 8'd0, 16'h0000);
        send_pulse(16'h2064, 8'd0, 16'h0064);
        send_pulse(16'h2000, 8'd0, 16'h0064);

        // rotation count falls back, then jumps by several rotations at once
        wait_results_done(8);
        write_reg(CFG_PULSES_PER_ROTATION, 24'd8);
        send_pulse(16'h2100, 8'd0, 16'h0064);
        send_pulse(16'h2200, 8'd0, 16'h0064);
        wait_results_done(8);
        write_reg(CFG_PULSES_PER_ROTATION, 24'd1);
        send_pulse(16'h2300, 8'd0, 16'h0064);
        wait_results_done(8);
    endtask

    // register extremes: all ones, the lowest legal setting, then all zero
    task automatic test_register_extremes();
        write_reg(CFG_TICK_RATE, 24'hFF_FFFF);
        set_ratios(8'hFF, 8'hFF, 8'hFF);
        // clean train longer than one rotation of 255 pulses
        drive_pulse_train(260, 0);
        wait_results_done(8);

        write_reg(CFG_TICK_RATE, 24'd1);
        set_ratios(8'd1, 8'd1, 8'd1);
        drive_pulse_train(40, 15);
        wait_results_done(8);

        write_reg(CFG_TICK_RATE, 24'd0);
        set_ratios(8'd0, 8'd0, 8'd0);
        drive_pulse_train(40, 15);
        wait_results_done(8);
    endtask

    // random settings, with and without idling on either side
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            gaps_on   = (phase != 0);
            rx_stalls = (phase != 0);
            write_reg(CFG_TICK_RATE, CFG_DATA_W'($urandom_range(1000, 24'hFF_FFFF)));
            set_ratios(RATIO_W'($urandom_range(1, 6)), RATIO_W'($urandom_range(1, 255)),
                       RATIO_W'($urandom_range(1, 255)));
            drive_pulse_train(70, 15);
            wait_results_done(8);
        end
        gaps_on   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // sink holds off for a long stretch while the source keeps offering
    task automatic test_backpressure_fill();
        gaps_on = 1'b0;
        write_reg(CFG_PULSES_PER_ROTATION, 24'd3);
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        drive_pulse_train(16, 0);
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatches     = 0;
        tx_cap         = '0;
        burst_left     = 1;
        gaps_on        = 1'b1;
        rx_stalls      = 1'b1;
        hold_left      = 0;
        i_rst_n        = 1'b0;
        pulse_ch.valid = 1'b0;
        pulse_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.addr    = CFG_TICK_RATE;
        cfg_ch.wdata   = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_backpressure_fill();

        // settle long enough for the longest pulse to finish
        wait_results_done(300);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
